FILE: rtl/lsnm_pkg.sv
// lattice site to node mapper: shared types, constants and divider step
`default_nettype none

package lsnm_pkg;

    localparam int NLANE = 4;
    localparam int CW = 10;
    localparam int EW = 11;
    localparam int LSW = 25;
    localparam int DIV_STAGES = 5;

    localparam logic [EW-1:0] EDGE_MAX = 11'd1024;
    localparam logic [16:0] NODE_CAP = 17'h10000;
    localparam logic [25:0] RAW_CAP = 26'h2000000;
    localparam logic [15:0] NODE_LIM = 16'hFFFF;
    localparam logic [23:0] SLOT_LIM = 24'hFFFFFF;

    localparam logic [2:0] CFG_EDGE_X = 3'd0;
    localparam logic [2:0] CFG_EDGE_Y = 3'd1;
    localparam logic [2:0] CFG_EDGE_Z = 3'd2;
    localparam logic [2:0] CFG_EDGE_T = 3'd3;
    localparam logic [2:0] CFG_CUBES_X = 3'd4;
    localparam logic [2:0] CFG_CUBES_Y = 3'd5;
    localparam logic [2:0] CFG_CUBES_Z = 3'd6;
    localparam logic [2:0] CFG_LOCAL_SITES = 3'd7;

    typedef struct packed {
        logic [9:0] coord_x;
        logic [9:0] coord_y;
        logic [9:0] coord_z;
        logic [9:0] coord_t;
    } lsnm_in_t;

    typedef struct packed {
        logic [15:0] owner_node;
        logic [23:0] site_slot;
        logic        range_flag;
    } lsnm_out_t;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CW-1:0] dq;
    } div_st_t;

    // one restoring division step, quotient bits shift in from the right
    function automatic div_st_t div_step(logic [CW-1:0] rem, logic [CW-1:0] dq,
                                         logic [EW-1:0] dvs);
        logic [EW-1:0] t;
        div_st_t o;
        t = {rem, dq[CW-1]};
        o.dq = {dq[CW-2:0], 1'b0};
        if (t >= dvs)
        begin
            t = t - dvs;
            o.dq[0] = 1'b1;
        end
        o.rem = t[CW-1:0];
        return o;
    endfunction

    function automatic logic [EW-1:0] eff_edge(logic [EW-1:0] e);
        logic [EW-1:0] r;
        r = e;
        if (e == '0)
            r = 11'd1;
        else if (e > EDGE_MAX)
            r = EDGE_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lsnm_div_pipe.sv
// four-lane pipelined restoring divider, two quotient bits per stage
`default_nettype none

module lsnm_div_pipe
    import lsnm_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vld_in,
    input  wire logic [NLANE-1:0][CW-1:0]      dvd_in,
    input  wire logic [NLANE-1:0][EW-1:0]      dvs,
    input  wire logic                          par_in,
    output logic                               vld_out,
    output logic [NLANE-1:0][CW-1:0]           quo,
    output logic [NLANE-1:0][CW-1:0]           rem,
    output logic                               par_out
);

    logic [DIV_STAGES-1:0]                 vld_reg;
    logic [DIV_STAGES-1:0]                 par_reg;
    logic [DIV_STAGES-1:0][NLANE-1:0][CW-1:0] rem_reg, rem_next;
    logic [DIV_STAGES-1:0][NLANE-1:0][CW-1:0] dq_reg, dq_next;

    always_comb
    begin
        div_st_t a;
        div_st_t b;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                if (s == 0)
                    a = div_step('0, dvd_in[l], dvs[l]);
                else
                    a = div_step(rem_reg[s-1][l], dq_reg[s-1][l], dvs[l]);
                b = div_step(a.rem, a.dq, dvs[l]);
                rem_next[s][l] = b.rem;
                dq_next[s][l] = b.dq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dq_reg <= dq_next;
            par_reg <= {par_reg[DIV_STAGES-2:0], par_in};
        end
    end

    assign vld_out = vld_reg[DIV_STAGES-1];
    assign quo = dq_reg[DIV_STAGES-1];
    assign rem = rem_reg[DIV_STAGES-1];
    assign par_out = par_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/lattice_site_to_node_mapper_top.sv
// lattice site to node mapper: config registers, divider, mixed-radix stages, output
//
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    in_data (lsnm_in_t)
// out       out  out_valid/out_stall  out_data (lsnm_out_t)
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transfer per cycle while the output is not stalled; 5 divider stages,
// 3 multiply-add stages, one output register
// the whole pipe holds while the output register is full and stalled
// reset clears valid bits and restores the register defaults
// cfg_ready is always high
`default_nettype none

module lattice_site_to_node_mapper_top
    import lsnm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire lsnm_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output lsnm_out_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [24:0] cfg_data
);

    logic [NLANE-1:0][EW-1:0] edge_reg;
    logic [EW-1:0] cx_reg, cy_reg, cz_reg;
    logic [LSW-1:0] ls_reg;

    logic en;
    logic [NLANE-1:0][CW-1:0] dvd;
    logic par_in;
    logic dv_vld, dv_par;
    logic [NLANE-1:0][CW-1:0] q, r;

    logic m1_vld_reg, m2_vld_reg, m3_vld_reg, out_valid_reg;
    logic m1_par_reg, m2_par_reg, m3_par_reg;
    logic [CW-1:0] m1_qx_reg, m1_qy_reg, m1_rx_reg, m1_ry_reg, m2_qx_reg, m2_rx_reg;
    logic [16:0] m1_n_reg, m1_n_next, m2_n_reg, m2_n_next;
    logic [25:0] m1_r_reg, m1_r_next, m2_r_reg, m2_r_next, m3_raw_reg, m3_raw_next;
    logic [15:0] m3_node_reg, m3_node_next;
    logic m3_nflag_reg, m3_nflag_next;
    lsnm_out_t out_data_reg, out_data_next;

    logic [20:0] n1_full, r1_full;
    logic [28:0] n2_full, node_full;
    logic [37:0] r2_full, raw_full;
    logic [26:0] sum;
    logic [25:0] slot_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= {NLANE{11'd1}};
            cx_reg <= 11'd1;
            cy_reg <= 11'd1;
            cz_reg <= 11'd1;
            ls_reg <= 25'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EDGE_X:      edge_reg[0] <= eff_edge(cfg_data[EW-1:0]);
                CFG_EDGE_Y:      edge_reg[1] <= eff_edge(cfg_data[EW-1:0]);
                CFG_EDGE_Z:      edge_reg[2] <= eff_edge(cfg_data[EW-1:0]);
                CFG_EDGE_T:      edge_reg[3] <= eff_edge(cfg_data[EW-1:0]);
                CFG_CUBES_X:     cx_reg <= cfg_data[EW-1:0];
                CFG_CUBES_Y:     cy_reg <= cfg_data[EW-1:0];
                CFG_CUBES_Z:     cz_reg <= cfg_data[EW-1:0];
                CFG_LOCAL_SITES: ls_reg <= cfg_data;
                default:         ls_reg <= ls_reg;
            endcase
        end
    end

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign dvd = {in_data.coord_t, in_data.coord_z, in_data.coord_y, in_data.coord_x};
    assign par_in = in_data.coord_x[0] ^ in_data.coord_y[0] ^ in_data.coord_z[0]
                    ^ in_data.coord_t[0];

    lsnm_div_pipe u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (in_valid),
        .dvd_in  (dvd),
        .dvs     (edge_reg),
        .par_in  (par_in),
        .vld_out (dv_vld),
        .quo     (q),
        .rem     (r),
        .par_out (dv_par)
    );

    // innermost radix step: z with t
    always_comb
    begin
        n1_full = 21'(q[2]) + 21'(cz_reg) * 21'(q[3]);
        m1_n_next = (n1_full > 21'(NODE_CAP)) ? NODE_CAP : n1_full[16:0];
        r1_full = 21'(r[2]) + 21'(edge_reg[2]) * 21'(r[3]);
        m1_r_next = 26'(r1_full);
    end

    // y step, intermediates capped above the overflow thresholds
    always_comb
    begin
        n2_full = 29'(m1_qy_reg) + 29'(cy_reg) * 29'(m1_n_reg);
        m2_n_next = (n2_full > 29'(NODE_CAP)) ? NODE_CAP : n2_full[16:0];
        r2_full = 38'(m1_ry_reg) + 38'(edge_reg[1]) * 38'(m1_r_reg);
        m2_r_next = (r2_full > 38'(RAW_CAP)) ? RAW_CAP : r2_full[25:0];
    end

    // x step and node saturation
    always_comb
    begin
        node_full = 29'(m2_qx_reg) + 29'(cx_reg) * 29'(m2_n_reg);
        m3_nflag_next = node_full > 29'(NODE_LIM);
        m3_node_next = m3_nflag_next ? NODE_LIM : node_full[15:0];
        raw_full = 38'(m2_rx_reg) + 38'(edge_reg[0]) * 38'(m2_r_reg);
        m3_raw_next = (raw_full > 38'(RAW_CAP)) ? RAW_CAP : raw_full[25:0];
    end

    // odd sites go to the second half
    always_comb
    begin
        sum = m3_par_reg ? (27'(m3_raw_reg) + 27'(ls_reg)) : 27'(m3_raw_reg);
        slot_full = sum[26:1];
        out_data_next.owner_node = m3_node_reg;
        if (slot_full > 26'(SLOT_LIM))
        begin
            out_data_next.site_slot = SLOT_LIM;
            out_data_next.range_flag = 1'b1;
        end
        else
        begin
            out_data_next.site_slot = slot_full[23:0];
            out_data_next.range_flag = m3_nflag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= dv_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            out_valid_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_qx_reg <= q[0];
            m1_qy_reg <= q[1];
            m1_rx_reg <= r[0];
            m1_ry_reg <= r[1];
            m1_n_reg <= m1_n_next;
            m1_r_reg <= m1_r_next;
            m1_par_reg <= dv_par;
            m2_qx_reg <= m1_qx_reg;
            m2_rx_reg <= m1_rx_reg;
            m2_n_reg <= m2_n_next;
            m2_r_reg <= m2_r_next;
            m2_par_reg <= m1_par_reg;
            m3_node_reg <= m3_node_next;
            m3_nflag_reg <= m3_nflag_next;
            m3_raw_reg <= m3_raw_next;
            m3_par_reg <= m2_par_reg;
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    a_flag_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_flag |->
            out_data.owner_node == NODE_LIM || out_data.site_slot == SLOT_LIM)
        else $error("range flag without saturated field");

    a_rem_lt_edge: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld |-> r[0] < edge_reg[0] && r[3] < edge_reg[3])
        else $error("divider remainder not below edge");

    a_hold_m3: assert property (@(posedge clk) disable iff (!rst_n)
        m3_vld_reg && in_stall |=> m3_vld_reg)
        else $error("item lost in stalled pipe");

endmodule

`default_nettype wire

FILE: test/tb_lattice_site_to_node_mapper_top.sv
// testbench for the lattice site to node mapper: random and directed lookups checked against a predictor
`timescale 1ns / 1ps

module tb_lattice_site_to_node_mapper_top;
    import lsnm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    lsnm_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    lsnm_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [24:0] cfg_data;

    lattice_site_to_node_mapper_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    logic [10:0] m_edge[4];
    logic [10:0] m_cubes[3];
    logic [24:0] m_local_sites;

    lsnm_in_t  site_queue[$];
    lsnm_out_t mapping_queue[$];
    int        error_count;
    int        idle_pct;
    int        stall_pct;
    int        quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [10:0] clamp_edge(logic [10:0] e);
        if (e == 0)
            return 11'd1;
        if (e > 11'd1024)
            return 11'd1024;
        return e;
    endfunction

    function automatic lsnm_out_t map_site(lsnm_in_t s);
        longint unsigned c[4];
        longint unsigned e[4];
        longint unsigned node, raw, slot;
        lsnm_out_t r;
        c[0] = s.coord_x; c[1] = s.coord_y; c[2] = s.coord_z; c[3] = s.coord_t;
        for (int i = 0; i < 4; i++)
            e[i] = clamp_edge(m_edge[i]);
        node = c[0] / e[0] + m_cubes[0] * (c[1] / e[1] + m_cubes[1]
             * (c[2] / e[2] + m_cubes[2] * (c[3] / e[3])));
        raw = c[0] % e[0] + e[0] * (c[1] % e[1] + e[1]
            * (c[2] % e[2] + e[2] * (c[3] % e[3])));
        if (((c[0] + c[1] + c[2] + c[3]) & 1) == 0)
            slot = raw / 2;
        else
            slot = (raw + m_local_sites) / 2;
        r.range_flag = 1'b0;
        if (node > 64'hFFFF)
        begin
            node = 64'hFFFF;
            r.range_flag = 1'b1;
        end
        if (slot > 64'hFFFFFF)
        begin
            slot = 64'hFFFFFF;
            r.range_flag = 1'b1;
        end
        r.owner_node = node[15:0];
        r.site_slot = slot[23:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // valid stays high between back to back writes, the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [24:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LOCAL_SITES)
            m_local_sites = val;
        else if (idx >= CFG_CUBES_X)
            m_cubes[idx - CFG_CUBES_X] = val[10:0];
        else
            m_edge[idx] = val[10:0];
    endtask

    task automatic drain();
        while (site_queue.size() != 0 || mapping_queue.size() != 0 || in_valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic lsnm_in_t rand_site();
        lsnm_in_t s;
        s.coord_x = 10'($urandom);
        s.coord_y = 10'($urandom);
        s.coord_z = 10'($urandom);
        s.coord_t = 10'($urandom);
        if ($urandom_range(0, 7) == 0)
            s.coord_x = $urandom_range(0, 1) ? 10'h3FF : 10'h0;
        if ($urandom_range(0, 7) == 0)
            s.coord_t = $urandom_range(0, 1) ? 10'h3FF : 10'h0;
        return s;
    endfunction

    task automatic rand_config();
        logic [24:0] v;
        for (int i = 0; i < 7; i++)
        begin
            case ($urandom_range(0, 5))
                0: v = 25'd0;
                1: v = 25'd1;
                2: v = 25'd1024;
                3: v = 25'h7FF;
                4: v = 25'($urandom_range(1, 8));
                default: v = 25'($urandom_range(1, 64));
            endcase
            write_reg(3'(i), v);
        end
        case ($urandom_range(0, 3))
            0: v = 25'd0;
            1: v = 25'h1FFFFFF;
            2: v = 25'h1000000;
            default: v = 25'($urandom);
        endcase
        write_reg(CFG_LOCAL_SITES, v);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                mapping_queue.push_back(map_site(in_data));
            if (!in_valid || !in_stall)
            begin
                if (site_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_data <= site_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        lsnm_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (mapping_queue.size() == 0)
                    report_mismatch("unexpected transfer", out_data, 0);
                else
                begin
                    want = mapping_queue.pop_front();
                    if (out_data.owner_node !== want.owner_node)
                        report_mismatch("owner_node", out_data.owner_node, want.owner_node);
                    if (out_data.site_slot !== want.site_slot)
                        report_mismatch("site_slot", out_data.site_slot, want.site_slot);
                    if (out_data.range_flag !== want.range_flag)
                        report_mismatch("range_flag", out_data.range_flag, want.range_flag);
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[lattice_site_to_node_mapper_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        lsnm_in_t s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EDGE_X;
        cfg_data = '0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 4; i++)
            m_edge[i] = 11'd1;
        for (int i = 0; i < 3; i++)
            m_cubes[i] = 11'd1;
        m_local_sites = 25'd2;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, then extremes with zero and oversized edges
        site_queue.push_back('0);
        site_queue.push_back('1);
        site_queue.push_back('{10'd1, 10'd0, 10'd0, 10'd0});
        site_queue.push_back('{10'd1023, 10'd1023, 10'd1023, 10'd0});
        drain();
        write_reg(CFG_EDGE_X, 25'd0);
        write_reg(CFG_EDGE_Y, 25'h7FF);
        write_reg(CFG_EDGE_Z, 25'd1024);
        write_reg(CFG_EDGE_T, 25'd3);
        write_reg(CFG_CUBES_X, 25'h7FF);
        write_reg(CFG_CUBES_Y, 25'd0);
        write_reg(CFG_CUBES_Z, 25'd1024);
        write_reg(CFG_LOCAL_SITES, 25'h1FFFFFF);
        cfg_valid <= 1'b0;
        site_queue.push_back('0);
        site_queue.push_back('1);
        site_queue.push_back('{10'd1023, 10'd0, 10'd0, 10'd0});
        site_queue.push_back('{10'd0, 10'd1023, 10'd1023, 10'd1023});
        site_queue.push_back('{10'd1, 10'd2, 10'd3, 10'd5});
        drain();
        write_reg(CFG_EDGE_X, 25'd1);
        write_reg(CFG_EDGE_Y, 25'd1);
        write_reg(CFG_EDGE_Z, 25'd1);
        write_reg(CFG_EDGE_T, 25'd1);
        write_reg(CFG_CUBES_X, 25'd1024);
        write_reg(CFG_CUBES_Y, 25'd1024);
        write_reg(CFG_CUBES_Z, 25'd1024);
        write_reg(CFG_LOCAL_SITES, 25'd0);
        cfg_valid <= 1'b0;
        site_queue.push_back('1);
        site_queue.push_back('{10'd5, 10'd0, 10'd0, 10'd0});
        site_queue.push_back('{10'd0, 10'd0, 10'd0, 10'd0});
        drain();

        // random: phases of idling and stalling, new config per phase
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 70; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 70; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            rand_config();
            for (int k = 0; k < 75; k++)
            begin
                s = rand_site();
                site_queue.push_back(s);
            end
            drain();
        end
        stall_pct = 0;
        drain();
        if (error_count == 0)
            $display("[lattice_site_to_node_mapper_top] OK");
        else
            $display("[lattice_site_to_node_mapper_top] ERROR");
        $finish;
    end

endmodule
